// ===== rtl/core/dfcr_pkg.sv =====
package dfcr_pkg;

    localparam logic [7:0]  DELIMITER     = 8'h7e;
    localparam logic [7:0]  CHECK_BASE    = 8'hff;
    localparam logic [15:0] TIMEOUT_RESET = 16'd10000;
    localparam logic [15:0] MAXLEN_RESET  = 16'd128;

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 48;

    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_LEN_HI  = 3'd1,
        PH_LEN_LO  = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_CHECK   = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        RK_BYTE = 2'd0,
        RK_GOOD = 2'd1,
        RK_DROP = 2'd2
    } rkind_t;

    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_CHECKSUM = 3'd1,
        ERR_TIMEOUT  = 3'd2,
        ERR_TOO_LONG = 3'd3,
        ERR_EMPTY    = 3'd4
    } err_t;

    typedef enum logic {
        KIND_BYTE = 1'b0,
        KIND_TICK = 1'b1
    } ikind_t;

    typedef enum logic {
        CFG_TIMEOUT = 1'b0,
        CFG_MAX_LEN = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] rx_byte;
    } item_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [7:0]  payload_byte;
        logic [15:0] byte_index;
        logic [15:0] frame_length;
        logic [2:0]  error_code;
    } result_t;

endpackage

// ===== rtl/core/dfcr_in_stage.sv =====
module dfcr_in_stage
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [dfcr_pkg::IN_TDATA_W-1:0]    s_tdata,
    input  logic                               s_tuser,
    input  logic                               advance,
    output logic                               item_valid,
    output dfcr_pkg::item_t                    item
);
    import dfcr_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  take;

    assign s_tready = !valid_reg || advance;
    assign take     = s_tvalid && s_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.kind    <= s_tuser;
            item_reg.rx_byte <= s_tdata[7:0];
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== rtl/core/dfcr_parser.sv =====
module dfcr_parser
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [15:0]          cfg_data,
    input  logic                 advance,
    input  dfcr_pkg::item_t      item,
    output logic                 res_valid,
    output dfcr_pkg::result_t    res
);
    import dfcr_pkg::*;

    phase_t      phase_reg;
    phase_t      phase_next;
    logic [15:0] length_reg;
    logic [15:0] length_next;
    logic [15:0] count_reg;
    logic [15:0] count_next;
    logic [7:0]  sum_reg;
    logic [7:0]  sum_next;
    logic [15:0] timer_reg;
    logic [15:0] timer_next;
    logic [15:0] timeout_reg;
    logic [15:0] max_len_reg;

    logic [16:0] timer_inc;
    logic [15:0] hdr_len;
    logic [15:0] count_inc;
    logic [7:0]  want;

    assign timer_inc = {1'b0, timer_reg} + 17'd1;
    assign hdr_len   = {length_reg[15:8], item.rx_byte};
    assign count_inc = count_reg + 16'd1;
    assign want      = CHECK_BASE - sum_reg;

    // next state
    always_comb
    begin
        phase_next  = phase_reg;
        length_next = length_reg;
        count_next  = count_reg;
        sum_next    = sum_reg;
        timer_next  = timer_reg;
        if (item.kind == KIND_TICK)
        begin
            if (phase_reg != PH_HUNT)
            begin
                if (timer_inc > {1'b0, timeout_reg})
                begin
                    phase_next  = PH_HUNT;
                    length_next = '0;
                    count_next  = '0;
                    sum_next    = '0;
                    timer_next  = '0;
                end
                else
                begin
                    timer_next = timer_inc[15:0];
                end
            end
        end
        else
        begin
            timer_next = '0;
            unique case (phase_reg)
                PH_LEN_HI:
                begin
                    length_next = {item.rx_byte, 8'h00};
                    phase_next  = PH_LEN_LO;
                end
                PH_LEN_LO:
                begin
                    if (hdr_len == 16'd0 || hdr_len > max_len_reg)
                    begin
                        phase_next  = PH_HUNT;
                        length_next = '0;
                    end
                    else
                    begin
                        phase_next  = PH_PAYLOAD;
                        length_next = hdr_len;
                    end
                    count_next = '0;
                    sum_next   = '0;
                end
                PH_PAYLOAD:
                begin
                    sum_next   = sum_reg + item.rx_byte;
                    count_next = count_inc;
                    if (count_inc >= length_reg)
                    begin
                        phase_next = PH_CHECK;
                    end
                end
                PH_CHECK:
                begin
                    phase_next  = PH_HUNT;
                    length_next = '0;
                    count_next  = '0;
                    sum_next    = '0;
                end
                default:
                begin
                    phase_next = PH_HUNT;
                    if (item.rx_byte == DELIMITER)
                    begin
                        phase_next  = PH_LEN_HI;
                        length_next = '0;
                        count_next  = '0;
                        sum_next    = '0;
                    end
                end
            endcase
        end
    end

    // result
    always_comb
    begin
        res_valid        = 1'b0;
        res.result_kind  = RK_DROP;
        res.payload_byte = '0;
        res.byte_index   = '0;
        res.frame_length = '0;
        res.error_code   = ERR_NONE;
        if (item.kind == KIND_TICK)
        begin
            if (phase_reg == PH_LEN_HI || phase_reg == PH_LEN_LO ||
                phase_reg == PH_PAYLOAD || phase_reg == PH_CHECK)
            begin
                if (timer_inc > {1'b0, timeout_reg})
                begin
                    res_valid      = 1'b1;
                    res.byte_index = count_reg;
                    res.error_code = ERR_TIMEOUT;
                    if (phase_reg == PH_PAYLOAD || phase_reg == PH_CHECK)
                    begin
                        res.frame_length = length_reg;
                    end
                end
            end
        end
        else
        begin
            unique case (phase_reg)
                PH_LEN_LO:
                begin
                    if (hdr_len == 16'd0)
                    begin
                        res_valid      = 1'b1;
                        res.error_code = ERR_EMPTY;
                    end
                    else if (hdr_len > max_len_reg)
                    begin
                        res_valid        = 1'b1;
                        res.frame_length = hdr_len;
                        res.error_code   = ERR_TOO_LONG;
                    end
                end
                PH_PAYLOAD:
                begin
                    res_valid        = 1'b1;
                    res.result_kind  = RK_BYTE;
                    res.payload_byte = item.rx_byte;
                    res.byte_index   = count_reg;
                    res.frame_length = length_reg;
                end
                PH_CHECK:
                begin
                    res_valid        = 1'b1;
                    res.byte_index   = count_reg;
                    res.frame_length = length_reg;
                    if (want == item.rx_byte)
                    begin
                        res.result_kind = RK_GOOD;
                    end
                    else
                    begin
                        res.error_code = ERR_CHECKSUM;
                    end
                end
                default:
                begin
                    res_valid = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HUNT;
            length_reg <= '0;
            count_reg  <= '0;
            sum_reg    <= '0;
            timer_reg  <= '0;
        end
        else if (advance)
        begin
            phase_reg  <= phase_next;
            length_reg <= length_next;
            count_reg  <= count_next;
            sum_reg    <= sum_next;
            timer_reg  <= timer_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
            max_len_reg <= MAXLEN_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TIMEOUT: timeout_reg <= cfg_data;
                CFG_MAX_LEN: max_len_reg <= cfg_data;
                default:     timeout_reg <= timeout_reg;
            endcase
        end
    end

endmodule

// ===== rtl/core/dfcr_out_stage.sv =====
module dfcr_out_stage
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               load,
    input  dfcr_pkg::result_t                  res,
    output logic                               room,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [dfcr_pkg::OUT_TDATA_W-1:0]   m_tdata,
    output logic [1:0]                         m_tuser
);
    import dfcr_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign room = !valid_reg || m_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = res_reg.result_kind;
    assign m_tdata  = {5'b00000, res_reg.error_code, res_reg.frame_length,
                       res_reg.byte_index, res_reg.payload_byte};

endmodule

// ===== rtl/core/delimited_frame_checksum_receiver.sv =====
// Frame receiver for a byte stream with 0x7e delimiter, 16-bit big-endian length,
// payload and additive checksum. One byte or tick transfer is taken every clock unless
// the stall below holds it; a result passes the input register, then the result
// register, before it is presented, and can be taken at the following edge at the
// earliest. The only stall comes from the single result register: while it holds an
// untaken result, an item that yields a result waits, an item that yields none passes.
// Write timeout_ticks (index 0) and max_frame_length (index 1) only while idle.
module delimited_frame_checksum_receiver
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [dfcr_pkg::IN_TDATA_W-1:0]    s_tdata,   // rx_byte
    input  logic                               s_tuser,   // kind
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [dfcr_pkg::OUT_TDATA_W-1:0]   m_tdata,   // payload_byte, byte_index,
                                                          // frame_length, error_code
    output logic [1:0]                         m_tuser,   // result_kind
    input  logic                               cfg_we,
    input  logic                               cfg_index,
    input  logic [15:0]                        cfg_data
);
    import dfcr_pkg::*;

    logic    item_valid;
    item_t   item;
    logic    res_valid;
    result_t res;
    logic    room;
    logic    advance;

    assign advance = item_valid && (!res_valid || room);

    dfcr_in_stage u_in
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    dfcr_parser u_parser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .advance   (advance),
        .item      (item),
        .res_valid (res_valid),
        .res       (res)
    );

    dfcr_out_stage u_out
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (advance && res_valid),
        .res      (res),
        .room     (room),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// ===== rtl/core/dfcr_checker.sv =====
module dfcr_checker
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic [dfcr_pkg::OUT_TDATA_W-1:0]   m_tdata,
    input  logic [1:0]                         m_tuser
);
    import dfcr_pkg::*;

    // stalled result transfer holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == RK_BYTE || m_tuser == RK_GOOD || m_tuser == RK_DROP))
        else $error("bad result kind");

    // payload bytes and accepted frames carry no error, status items no byte
    a_byte_err: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != RK_DROP |-> m_tdata[42:40] == ERR_NONE)
        else $error("error code on non-drop result");

    a_status_byte: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != RK_BYTE |-> m_tdata[7:0] == 8'h00)
        else $error("payload byte on status result");

    // a payload byte always lies inside its frame
    a_index: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == RK_BYTE |-> m_tdata[23:8] < m_tdata[39:24])
        else $error("byte index beyond frame length");

endmodule

bind delimited_frame_checksum_receiver dfcr_checker u_dfcr_checker (.*);

// ===== test/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import dfcr_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int MAX_REPORTED   = 10;

    class frame_predictor;
        logic [15:0] timeout_ticks;
        logic [15:0] max_len;
        phase_t      phase;
        logic [15:0] length_reg;
        logic [15:0] rx_count;
        logic [15:0] idle_timer;
        logic [7:0]  sum;
        result_t     expected_results[$];
        int          mismatches;

        function new();
            timeout_ticks = TIMEOUT_RESET;
            max_len       = MAXLEN_RESET;
            mismatches    = 0;
            restart_hunt();
        endfunction

        function void restart_hunt();
            phase      = PH_HUNT;
            length_reg = '0;
            rx_count   = '0;
            idle_timer = '0;
            sum        = '0;
        endfunction

        function void write_register(cfg_idx_t idx, logic [15:0] value);
            if (idx == CFG_TIMEOUT)
                timeout_ticks = value;
            else
                max_len = value;
        endfunction

        function void push_result(rkind_t rk, logic [7:0] b, logic [15:0] idx,
                                  logic [15:0] len, err_t err);
            result_t r;
            r.result_kind  = rk;
            r.payload_byte = b;
            r.byte_index   = idx;
            r.frame_length = len;
            r.error_code   = err;
            expected_results.push_back(r);
        endfunction

        function void take_input(ikind_t kind, logic [7:0] b);
            logic [16:0] next;
            logic [15:0] len;
            logic [15:0] cnt;
            logic [15:0] idx;
            logic [7:0]  want;
            if (kind == KIND_TICK)
            begin
                if (phase == PH_HUNT)
                    return;
                next = {1'b0, idle_timer} + 17'd1;
                if (next > {1'b0, timeout_ticks})
                begin
                    len = (phase >= PH_PAYLOAD) ? length_reg : 16'd0;
                    cnt = rx_count;
                    restart_hunt();
                    push_result(RK_DROP, 8'd0, cnt, len, ERR_TIMEOUT);
                end
                else
                    idle_timer = next[15:0];
                return;
            end
            idle_timer = '0;
            case (phase)
                PH_HUNT:
                begin
                    if (b == DELIMITER)
                    begin
                        restart_hunt();
                        phase = PH_LEN_HI;
                    end
                end
                PH_LEN_HI:
                begin
                    length_reg = {b, 8'h00};
                    phase      = PH_LEN_LO;
                end
                PH_LEN_LO:
                begin
                    len = {length_reg[15:8], b};
                    if (len == 16'd0)
                    begin
                        restart_hunt();
                        push_result(RK_DROP, 8'd0, 16'd0, 16'd0, ERR_EMPTY);
                    end
                    else if (len > max_len)
                    begin
                        restart_hunt();
                        push_result(RK_DROP, 8'd0, 16'd0, len, ERR_TOO_LONG);
                    end
                    else
                    begin
                        length_reg = len;
                        rx_count   = '0;
                        sum        = '0;
                        phase      = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD:
                begin
                    idx      = rx_count;
                    sum      = sum + b;
                    rx_count = rx_count + 16'd1;
                    if (rx_count >= length_reg)
                        phase = PH_CHECK;
                    push_result(RK_BYTE, b, idx, length_reg, ERR_NONE);
                end
                default:
                begin
                    want = CHECK_BASE - sum;
                    len  = length_reg;
                    cnt  = rx_count;
                    restart_hunt();
                    if (want == b)
                        push_result(RK_GOOD, 8'd0, cnt, len, ERR_NONE);
                    else
                        push_result(RK_DROP, 8'd0, cnt, len, ERR_CHECKSUM);
                end
            endcase
        endfunction

        function void note_mismatch(string msg);
            mismatches++;
            if (mismatches <= MAX_REPORTED)
                $display("mismatch: %s", msg);
        endfunction

        function void check_output(logic [1:0] rk, logic [OUT_TDATA_W-1:0] data);
            result_t want;
            result_t got;
            got.result_kind  = rk;
            got.payload_byte = data[7:0];
            got.byte_index   = data[23:8];
            got.frame_length = data[39:24];
            got.error_code   = data[42:40];
            if (expected_results.size() == 0)
            begin
                note_mismatch($sformatf({"unexpected result kind %0d byte %02h ",
                                         "index %0d len %0d err %0d"},
                                        got.result_kind, got.payload_byte, got.byte_index,
                                        got.frame_length, got.error_code));
                return;
            end
            want = expected_results.pop_front();
            if (got != want || data[OUT_TDATA_W-1:43] != '0)
                note_mismatch($sformatf({"expected kind %0d byte %02h index %0d len %0d ",
                                         "err %0d, got kind %0d byte %02h index %0d ",
                                         "len %0d err %0d pad %0h"},
                                        want.result_kind, want.payload_byte, want.byte_index,
                                        want.frame_length, want.error_code,
                                        got.result_kind, got.payload_byte, got.byte_index,
                                        got.frame_length, got.error_code,
                                        data[OUT_TDATA_W-1:43]));
        endfunction

        function int pending();
            return expected_results.size();
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic                   s_tuser   = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [1:0]             m_tuser;
    logic                   cfg_we    = 1'b0;
    logic                   cfg_index = 1'b0;
    logic [15:0]            cfg_data  = '0;

    frame_predictor predictor;
    int items_sent  = 0;
    int burst_left  = 0;
    int idle_cycles = 0;
    int ready_pct   = 100;
    int ready_cycle = 0;

    delimited_frame_checksum_receiver i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // result side: check each transfer, stall on a pattern of its own
    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
            predictor.check_output(m_tuser, m_tdata);
        if (ready_cycle == 0)
        begin
            ready_cycle = $urandom_range(50, 300);
            case ($urandom_range(0, 2))
                0:       ready_pct = 100;
                1:       ready_pct = 70;
                default: ready_pct = 25;
            endcase
        end
        else
            ready_cycle--;
        m_tready <= ($urandom_range(1, 100) <= ready_pct);
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("delimited_frame_checksum_receiver test failed");
            $finish;
        end
    end

    function automatic int min_int(int a, int b);
        return (a < b) ? a : b;
    endfunction

    task automatic send_item(ikind_t kind, logic [7:0] b);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= kind;
        do
            @(posedge clk);
        while (!s_tready);
        predictor.take_input(kind, b);
        items_sent++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(0, 10);
        end
    endtask

    task automatic send_ticks(int n);
        repeat (n) send_item(KIND_TICK, 8'($urandom()));
    endtask

    task automatic maybe_ticks(int max_ticks);
        if (max_ticks > 0 && $urandom_range(0, 3) == 0)
            send_ticks($urandom_range(1, max_ticks));
    endtask

    // delimiter, big-endian length, payload, checksum; ticks kept within the timeout
    task automatic send_frame(logic [7:0] payload[$], bit good, int max_ticks);
        logic [15:0] len;
        logic [7:0]  sum;
        logic [7:0]  cks;
        len = 16'(payload.size());
        sum = '0;
        send_item(KIND_BYTE, DELIMITER);
        maybe_ticks(max_ticks);
        send_item(KIND_BYTE, len[15:8]);
        maybe_ticks(max_ticks);
        send_item(KIND_BYTE, len[7:0]);
        foreach (payload[i])
        begin
            maybe_ticks(max_ticks);
            send_item(KIND_BYTE, payload[i]);
            sum = sum + payload[i];
        end
        cks = CHECK_BASE - sum;
        if (!good)
            cks = cks ^ 8'($urandom_range(1, 255));
        maybe_ticks(max_ticks);
        send_item(KIND_BYTE, cks);
    endtask

    task automatic send_header(logic [15:0] len);
        send_item(KIND_BYTE, DELIMITER);
        send_item(KIND_BYTE, len[15:8]);
        send_item(KIND_BYTE, len[7:0]);
    endtask

    task automatic random_payload(int n, ref logic [7:0] payload[$]);
        payload = {};
        repeat (n) payload.push_back(8'($urandom()));
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (predictor.pending() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic configure(logic [15:0] timeout, logic [15:0] max_len);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_TIMEOUT;
        cfg_data  <= timeout;
        @(posedge clk);
        predictor.write_register(CFG_TIMEOUT, timeout);
        cfg_index <= CFG_MAX_LEN;
        cfg_data  <= max_len;
        @(posedge clk);
        predictor.write_register(CFG_MAX_LEN, max_len);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic run_random(int n_items);
        int          target;
        int          choice;
        int          len;
        int          stop;
        int          tmo;
        int          mx;
        logic [15:0] hdr;
        logic [7:0]  payload[$];
        target = items_sent + n_items;
        while (items_sent < target)
        begin
            tmo    = predictor.timeout_ticks;
            mx     = predictor.max_len;
            choice = $urandom_range(0, 99);
            if (choice < 65)
            begin
                len = $urandom_range(1, min_int(mx, ($urandom_range(0, 9) == 0) ? 40 : 10));
                random_payload(len, payload);
                if ($urandom_range(0, 9) == 0)
                    payload[$urandom_range(0, len - 1)] = DELIMITER;
                send_frame(payload, $urandom_range(0, 7) != 0, min_int(tmo, 4));
            end
            else if (choice < 72)
            begin
                repeat ($urandom_range(1, 4))
                    send_item(KIND_BYTE, ($urandom_range(0, 4) == 0) ? 8'h00 : 8'($urandom()));
            end
            else if (choice < 80)
                send_ticks($urandom_range(1, 3));
            else if (choice < 87 && mx < 16'hffff)
            begin
                hdr = 16'($urandom_range(mx + 1, 16'hffff));
                send_header(hdr);
            end
            else if (choice < 92)
                send_header(16'd0);
            else if (tmo <= 16)
            begin
                // frame cut short, then left to time out
                len = $urandom_range(1, min_int(mx, 6));
                random_payload(len, payload);
                stop = $urandom_range(1, len + 2);
                send_item(KIND_BYTE, DELIMITER);
                send_item(KIND_BYTE, 8'(len >> 8));
                if (stop >= 2)
                    send_item(KIND_BYTE, 8'(len));
                for (int i = 0; i < stop - 2; i++)
                    send_item(KIND_BYTE, payload[i]);
                send_ticks(tmo + 1);
            end
            else
            begin
                random_payload($urandom_range(1, min_int(mx, 8)), payload);
                send_frame(payload, 1'b0, 0);
            end
        end
    endtask

    initial
    begin
        logic [7:0] payload[$];
        predictor = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_ticks(2);
        send_item(KIND_BYTE, 8'h00);
        send_item(KIND_BYTE, 8'hff);
        payload = {8'hff};
        send_frame(payload, 1'b1, 0);
        payload = {8'h00};
        send_frame(payload, 1'b0, 0);
        send_header(16'd0);
        send_header(16'hffff);

        configure(16'd2, 16'd3);
        payload = {8'h7e, 8'h00, 8'h80};
        send_frame(payload, 1'b1, 2);
        send_header(16'd4);
        send_item(KIND_BYTE, DELIMITER);
        send_item(KIND_BYTE, 8'h00);
        send_ticks(3);
        send_header(16'd2);
        send_item(KIND_BYTE, 8'haa);
        send_ticks(2);
        send_item(KIND_BYTE, 8'hbb);
        send_ticks(3);

        configure(16'd1, 16'd1);
        run_random(300);
        configure(16'd5, 16'd12);
        run_random(300);
        configure(16'hffff, 16'hffff);
        random_payload(300, payload);
        send_frame(payload, 1'b1, 4);
        run_random(250);
        configure(16'd3, 16'd255);
        run_random(300);
        configure(TIMEOUT_RESET, MAXLEN_RESET);
        run_random(250);

        drain();
        repeat (10) @(posedge clk);
        if (predictor.pending() != 0)
            predictor.note_mismatch($sformatf("%0d results never arrived", predictor.pending()));
        if (predictor.mismatches == 0)
            $display("delimited_frame_checksum_receiver test passed");
        else
            $display("delimited_frame_checksum_receiver test failed");
        $finish;
    end

endmodule
